@@ src/ctmts_pkg.sv @@
`timescale 1ns / 1ps

package ctmts_pkg;

  // field widths
  localparam int DATA_WIDTH  = 32;
  localparam int CPU_WIDTH   = 10;
  localparam int COUNT_WIDTH = $clog2(DATA_WIDTH);

  // cycles per microsecond after reset
  localparam logic [CPU_WIDTH-1:0] CPU_RESET = CPU_WIDTH'(72);

  // divider status toward the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ src/ctmts_div.sv @@
`timescale 1ns / 1ps

module ctmts_div
  import ctmts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [CPU_WIDTH-1:0]  divisor,
  output div_status_t           status,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [CPU_WIDTH-1:0]  remainder
);

  logic [DATA_WIDTH-1:0]  acc;
  logic [CPU_WIDTH-1:0]   rem;
  logic [COUNT_WIDTH-1:0] count;
  logic                   busy;
  logic                   done;

  logic [CPU_WIDTH:0]   rem_sh;
  logic [CPU_WIDTH+1:0] diff;
  logic                 ge;
  logic [CPU_WIDTH-1:0] rem_next;

  // one restoring step: bring down the next dividend bit, try the subtract
  always_comb begin
    rem_sh   = {rem, acc[DATA_WIDTH-1]};
    diff     = {1'b0, rem_sh} - {2'b00, divisor};
    ge       = !diff[CPU_WIDTH+1];
    rem_next = ge ? diff[CPU_WIDTH-1:0] : rem_sh[CPU_WIDTH-1:0];
  end

  // dividend shifts out msb first, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= '0;
      acc   <= dividend;
      rem   <= '0;
    end else if (busy) begin
      acc   <= {acc[DATA_WIDTH-2:0], ge};
      rem   <= rem_next;
      count <= count + COUNT_WIDTH'(1);
      if (count == COUNT_WIDTH'(DATA_WIDTH - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = acc;
  assign remainder   = rem;

endmodule

@@ src/ctmts_out_stage.sv @@
`timescale 1ns / 1ps

module ctmts_out_stage
  import ctmts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] push_data,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] timestamp_us
);

  // slot can take a new item when empty or being drained this cycle
  assign free = !out_valid || !out_stall;

  // output holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push && free) begin
      out_valid    <= 1'b1;
      timestamp_us <= push_data;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ src/cycle_to_microsecond_timestamp_core.sv @@
`timescale 1ns / 1ps
// Converts samples of a free-running 32-bit cycle counter to a 32-bit
// microsecond timestamp.
// Input channel: in_valid / in_stall with counter_sample; the core raises
// in_stall while it works on an item and takes one item at a time.
// Output channel: out_valid / out_stall with timestamp_us; one item out for
// every item in. The result sits in an output register, so the core accepts
// the next item while a finished timestamp still waits on out_stall.
// Config: cfg_write with cfg_data sets cycles_per_us (write only when idle).
// Processing: a sample that moved the counter, with cycles_per_us nonzero,
// goes through the leftover update and divider load, the bit-serial divider
// (one quotient bit per cycle), and the handoff to the output register. An
// unchanged sample, or cycles_per_us of zero, skips the divider. The input
// reopens only after the handoff, so the core finishes each item before it
// takes the next.
// When the receiver stalls, the finished item waits in the controller until
// the output register frees up.
// Reset clears the timestamp, leftover and last sample, sets cycles_per_us
// to 72, and leaves both channels empty.

module cycle_to_microsecond_timestamp_core
  import ctmts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CPU_WIDTH-1:0]  cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] counter_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] timestamp_us
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  state_t                state;
  logic [CPU_WIDTH-1:0]  cycles_per_us;
  logic [DATA_WIDTH-1:0] last_sample;
  logic [DATA_WIDTH-1:0] leftover_cycles;
  logic [DATA_WIDTH-1:0] micro_total;
  logic [DATA_WIDTH-1:0] sample_hold;
  logic                  add_quot;

  logic [DATA_WIDTH-1:0] prep_sum;
  logic                  prep_div;
  logic [DATA_WIDTH-1:0] total_next;
  logic                  div_start;
  div_status_t           div_stat;
  logic [DATA_WIDTH-1:0] div_quot;
  logic [CPU_WIDTH-1:0]  div_rem;
  logic                  out_push;
  logic                  out_free;

  // leftover plus wrapped counter difference
  always_comb begin
    prep_sum   = leftover_cycles + (sample_hold - last_sample);
    prep_div   = (sample_hold != last_sample) && (cycles_per_us != '0);
    total_next = micro_total + (add_quot ? div_quot : '0);
    div_start  = (state == S_PREP) && prep_div;
    out_push   = (state == S_FIN);
  end

  assign in_stall = (state != S_IDLE);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_us <= CPU_RESET;
    end else if (cfg_write) begin
      cycles_per_us <= cfg_data;
    end
  end

  // item sequencer and timestamp state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      last_sample     <= '0;
      leftover_cycles <= '0;
      micro_total     <= '0;
      add_quot        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_hold <= counter_sample;
            state       <= S_PREP;
          end
        end
        S_PREP: begin
          last_sample <= sample_hold;
          add_quot    <= prep_div;
          if (prep_div) begin
            state <= S_DIV;
          end else begin
            leftover_cycles <= prep_sum;
            state           <= S_FIN;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            leftover_cycles <= DATA_WIDTH'(div_rem);
            state           <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            micro_total <= total_next;
            add_quot    <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ctmts_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (prep_sum),
    .divisor   (cycles_per_us),
    .status    (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  ctmts_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (out_push),
    .push_data    (total_next),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .timestamp_us (timestamp_us)
  );

  // divider only reports completion while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider done outside of division state");

  // an accepted item always moves to the leftover update
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_PREP))
    else $error("accepted item did not start processing");

  // the timestamp holds while the division runs
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> $stable(micro_total))
    else $error("timestamp changed during division");

  // divider is busy for the whole division state until it reports done
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV) && !div_stat.done) |-> div_stat.busy)
    else $error("division state without a busy divider");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ctmts_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int LONG_HOLD     = 600;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 86;
  localparam int MAX_REPORTS   = 10;

  // directed samples at the reset divisor, CPU_RESET
  localparam logic [DATA_WIDTH-1:0] DIRECTED_RESET [10] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0047, 32'h0000_0048,
    32'h0000_008f, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h8000_0000
  };
  // directed samples with division disabled, leftover keeps growing
  localparam logic [DATA_WIDTH-1:0] DIRECTED_NODIV [5] = '{
    32'h0000_0005, 32'h0000_0005, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff
  };
  // directed samples at a divisor of 1, drains the big leftover
  localparam logic [DATA_WIDTH-1:0] DIRECTED_ONE [3] = '{
    32'h8000_0000, 32'h8000_0001, 32'h8000_0001
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CPU_WIDTH-1:0]  cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DATA_WIDTH-1:0] counter_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_WIDTH-1:0] timestamp_us;

  // local copy of the timestamp state
  logic [CPU_WIDTH-1:0]  model_cpu = CPU_RESET;
  logic [DATA_WIDTH-1:0] model_last = '0;
  logic [DATA_WIDTH-1:0] model_leftover = '0;
  logic [DATA_WIDTH-1:0] model_total = '0;

  logic [DATA_WIDTH-1:0] sample_q[$];
  logic [DATA_WIDTH-1:0] expected_ts_q[$];

  int error_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_pct = 0;
  int mode_left = 0;

  cycle_to_microsecond_timestamp_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .counter_sample (counter_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .timestamp_us   (timestamp_us)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // fold one counter sample into the timestamp state, return the new total
  function automatic logic [DATA_WIDTH-1:0] advance_timestamp(input logic [DATA_WIDTH-1:0] sample);
    logic [DATA_WIDTH-1:0] whole;
    logic [DATA_WIDTH-1:0] divisor;
    divisor = {{(DATA_WIDTH-CPU_WIDTH){1'b0}}, model_cpu};
    if (sample != model_last) begin
      model_leftover = model_leftover + (sample - model_last);
      model_last = sample;
      if (model_cpu != '0) begin
        whole = model_leftover / divisor;
        model_total = model_total + whole;
        model_leftover = model_leftover - whole * divisor;
      end
    end
    return model_total;
  endfunction

  // sender: bursts of items with random gaps, predicts on accept
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_ts_q.push_back(advance_timestamp(counter_sample));
      end
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        in_valid <= 1'b1;
        counter_sample <= sample_q.pop_front();
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes at random intervals, plus long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 90;
        endcase
        mode_left = $urandom_range(32, 300);
      end else begin
        mode_left = mode_left - 1;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [DATA_WIDTH-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_ts_q.size() == 0) begin
        error_count++;
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected item: timestamp_us %h", timestamp_us);
        end
        mismatch_count++;
      end else begin
        want = expected_ts_q.pop_front();
        if (timestamp_us !== want) begin
          error_count++;
          if (mismatch_count < MAX_REPORTS) begin
            $display("timestamp_us mismatch: expected %h got %h", want, timestamp_us);
          end
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cycle_to_microsecond_timestamp_core regression: fail");
      $finish;
    end
  end

  // wait until every queued item went in and every result came out
  task automatic wait_idle();
    do @(negedge clk);
    while (!(sample_q.size() == 0 && !in_valid && expected_ts_q.size() == 0));
    repeat (4) @(negedge clk);
  endtask

  // write cycles_per_us while the core is idle
  task automatic write_cpu(input logic [CPU_WIDTH-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    model_cpu = value;
  endtask

  // stimulus sequence
  initial begin
    logic [DATA_WIDTH-1:0] counter_now;
    logic [CPU_WIDTH-1:0]  cpu;
    int                    step_cpu;
    int                    pick;
    counter_now = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: unchanged samples, wrap of the counter, reset setting
    foreach (DIRECTED_RESET[i]) sample_q.push_back(DIRECTED_RESET[i]);
    wait_idle();

    // directed: divisor of zero, total holds
    write_cpu('0);
    foreach (DIRECTED_NODIV[i]) sample_q.push_back(DIRECTED_NODIV[i]);
    wait_idle();

    // directed: divisor of one
    write_cpu(CPU_WIDTH'(1));
    foreach (DIRECTED_ONE[i]) sample_q.push_back(DIRECTED_ONE[i]);
    wait_idle();
    counter_now = DIRECTED_ONE[2];

    // random phases, each at its own setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: cpu = CPU_WIDTH'(1023);
        1: cpu = CPU_WIDTH'(1000);
        2: cpu = '0;
        3: cpu = CPU_WIDTH'(1);
        4: cpu = CPU_RESET;
        5: cpu = CPU_WIDTH'(2);
        default: cpu = CPU_WIDTH'($urandom_range(1, 1000));
      endcase
      write_cpu(cpu);
      step_cpu = (cpu == '0) ? 72 : int'(cpu);
      if (p == 1 || p == 7) hold_req++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          counter_now = counter_now + DATA_WIDTH'($urandom_range(0, 4 * step_cpu));
        end else if (pick < 70) begin
          // repeated sample
        end else if (pick < 82) begin
          counter_now = counter_now + DATA_WIDTH'($urandom_range(0, 2000000));
        end else if (pick < 94) begin
          counter_now = $urandom;
        end else begin
          // counter seems to step back, wraps to a huge difference
          counter_now = counter_now - DATA_WIDTH'($urandom_range(1, 1000));
        end
        sample_q.push_back(counter_now);
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (expected_ts_q.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("cycle_to_microsecond_timestamp_core regression: pass");
    end else begin
      $display("cycle_to_microsecond_timestamp_core regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ctmts_pkg.sv
src/ctmts_div.sv
src/ctmts_out_stage.sv
src/cycle_to_microsecond_timestamp_core.sv
test/testbench.sv
